// ===== design/mmp_pkg.sv =====
`default_nettype none

package mmp_pkg;

    localparam int unsigned WORD_W     = 64;
    localparam int unsigned COUNT_W    = 61;
    localparam int unsigned SLOT_W     = 3;
    localparam int unsigned VBYTES_W   = 4;
    localparam int unsigned BYTES_WORD = 8;
    localparam logic [7:0]  PAD_BYTE   = 8'h80;

    // Which word the datapath loads into the output register
    typedef enum logic [2:0] {
        WSEL_DATA = 3'd0,   // message word as received
        WSEL_PAD  = 3'd1,   // partial word, 0x80 after the valid bytes
        WSEL_MARK = 3'd2,   // lone 0x80 word after a full last word
        WSEL_ZERO = 3'd3,   // zero fill
        WSEL_LEN  = 3'd4    // bit length, ends the message
    } t_wsel;

    typedef struct packed {
        logic  load;
        t_wsel sel;
    } t_cmd;

    typedef struct packed {
        logic adv;        // output register free this cycle
        logic slot_six;   // word loaded now lands in slot 6
        logic full_last;  // last item carries eight bytes
    } t_status;

endpackage

`default_nettype wire

// ===== design/mmp_ctrl.sv =====
`default_nettype none

module mmp_ctrl
    import mmp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_in_last,
    input  wire t_status i_status,
    output logic         o_in_ready,
    output t_cmd         o_cmd
);

    typedef enum logic [3:0] {
        ST_PASS = 4'b0001,
        ST_MARK = 4'b0010,
        ST_ZERO = 4'b0100,
        ST_LEN  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // after a padding word: length next if it sat in slot 6, else zero fill
    t_state fill_next;
    assign fill_next = i_status.slot_six ? ST_LEN : ST_ZERO;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.sel  = WSEL_ZERO;
        unique case (r_state)
            ST_PASS: begin
                o_in_ready = i_status.adv;
                if (i_in_valid && i_status.adv) begin
                    o_cmd.load = 1'b1;
                    if (!i_in_last) begin
                        o_cmd.sel = WSEL_DATA;
                    end else if (i_status.full_last) begin
                        o_cmd.sel = WSEL_DATA;
                        n_state   = ST_MARK;
                    end else begin
                        o_cmd.sel = WSEL_PAD;
                        n_state   = fill_next;
                    end
                end
            end
            ST_MARK: begin
                o_cmd.sel = WSEL_MARK;
                if (i_status.adv) begin
                    o_cmd.load = 1'b1;
                    n_state    = fill_next;
                end
            end
            ST_ZERO: begin
                o_cmd.sel = WSEL_ZERO;
                if (i_status.adv) begin
                    o_cmd.load = 1'b1;
                    n_state    = fill_next;
                end
            end
            ST_LEN: begin
                o_cmd.sel = WSEL_LEN;
                if (i_status.adv) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_PASS;
                end
            end
            default: begin
                n_state = ST_PASS;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_PASS;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== design/mmp_dp.sv =====
`default_nettype none

module mmp_dp
    import mmp_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    input  wire logic [WORD_W-1:0]   i_data_word,
    input  wire logic [VBYTES_W-1:0] i_valid_bytes,
    input  wire logic                i_out_ready,
    output t_status                  o_status,
    output logic                     o_out_valid,
    output logic [WORD_W-1:0]        o_out_word,
    output logic [SLOT_W-1:0]        o_word_index,
    output logic                     o_block_last,
    output logic                     o_message_last
);

    logic                r_out_valid;
    logic [WORD_W-1:0]   r_word;
    logic [SLOT_W-1:0]   r_index;
    logic                r_block_last;
    logic                r_msg_last;
    logic [COUNT_W-1:0]  r_count;
    logic [SLOT_W-1:0]   r_slot;

    logic [WORD_W-1:0]   pad_word;
    logic [WORD_W-1:0]   n_word;
    logic [COUNT_W-1:0]  n_count;
    logic                full;

    assign full = (i_valid_bytes >= VBYTES_W'(BYTES_WORD));

    // keep bytes below the valid count, 0x80 in the first free byte
    always_comb begin
        for (int i = 0; i < BYTES_WORD; i++) begin
            if (VBYTES_W'(i) < i_valid_bytes) begin
                pad_word[i*8 +: 8] = i_data_word[i*8 +: 8];
            end else if (VBYTES_W'(i) == i_valid_bytes) begin
                pad_word[i*8 +: 8] = PAD_BYTE;
            end else begin
                pad_word[i*8 +: 8] = 8'h00;
            end
        end
    end

    always_comb begin
        n_count = r_count;
        unique case (i_cmd.sel)
            WSEL_DATA: begin
                n_word  = i_data_word;
                n_count = r_count + COUNT_W'(BYTES_WORD);
            end
            WSEL_PAD: begin
                n_word  = pad_word;
                n_count = r_count + COUNT_W'(i_valid_bytes);
            end
            WSEL_MARK: n_word = WORD_W'(PAD_BYTE);
            WSEL_ZERO: n_word = '0;
            WSEL_LEN: begin
                n_word  = {r_count, 3'b000};
                n_count = '0;
            end
            default:   n_word = '0;
        endcase
    end

    assign o_status.adv       = !r_out_valid || i_out_ready;
    assign o_status.slot_six  = (r_slot == SLOT_W'(6));
    assign o_status.full_last = full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_slot      <= '0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
            r_count     <= n_count;
            r_slot      <= r_slot + SLOT_W'(1);
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word       <= n_word;
            r_index      <= r_slot;
            r_block_last <= (r_slot == '1);
            r_msg_last   <= (i_cmd.sel == WSEL_LEN);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_word     = r_word;
    assign o_word_index   = r_index;
    assign o_block_last   = r_block_last;
    assign o_message_last = r_msg_last;

endmodule

`default_nettype wire

// ===== design/md5_message_padder.sv =====
// MD5 message padder. Message words arrive on the s_axis side as 8-byte
// little-endian words (first byte in tdata[7:0]); tlast marks the final
// transaction, whose tdata[67:64] gives its valid byte count (0..8, larger
// values count as 8; ignored on other transactions). Words leave on m_axis in
// 64-byte blocks, numbered 0..7 in tuser[2:0], with tuser[3] on the eighth
// word. After the last valid byte the block appends 0x80, zero fill and the
// message length in bits (modulo 2^64, little-endian) as the eighth word of
// a block, flagged by m_axis tlast; an extra block is added when the 0x80
// byte falls in the eighth word, and an empty message yields one pad block.
// Message words pass through while m_axis is not stalled; the last
// transaction yields 2 to 10 output words, input held off while the padding
// sequencer feeds the single output register one word each cycle it is free.
// A full output register still accepts input in the same cycle it is drained.
`default_nettype none

module md5_message_padder
    import mmp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,   // [63:0] data_word, [67:64] valid_bytes, rest 0
    input  wire logic        s_axis_tlast,   // is_last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // [63:0] out_word
    output logic [7:0]       m_axis_tuser,   // [2:0] word_index, [3] block_last, rest 0
    output logic             m_axis_tlast    // message_last
);

    t_cmd             cmd;
    t_status          status;
    logic [SLOT_W-1:0] word_index;
    logic             block_last;

    // sequencer: passes message words, then walks the pad words
    mmp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .i_status   (status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    // byte count, block slot, word build and output register
    mmp_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_data_word    (s_axis_tdata[WORD_W-1:0]),
        .i_valid_bytes  (s_axis_tdata[WORD_W +: VBYTES_W]),
        .i_out_ready    (m_axis_tready),
        .o_status       (status),
        .o_out_valid    (m_axis_tvalid),
        .o_out_word     (m_axis_tdata),
        .o_word_index   (word_index),
        .o_block_last   (block_last),
        .o_message_last (m_axis_tlast)
    );

    assign m_axis_tuser = {4'b0000, block_last, word_index};

endmodule

`default_nettype wire
